// File: rtl/ecnidc_pkg.sv
// Shared types and constants for the congestion-notification injection throttle.
// Holds the input/result word structs, the per-flow state record and the codes.
// No dependencies.
`default_nettype none

package ecnidc_pkg;

  localparam int DELAY_W = 16;
  localparam int TIMER_W = 16;
  localparam int WAIT_W  = 24;
  localparam int SCALE_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STATE_DEPTH = 1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_FLIT  = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY_PERIOD  = 3'd0,
    REG_TIMER_ONLY    = 3'd1,
    REG_WAIT_SCALE    = 3'd2,
    REG_DELAY_STEP    = 3'd3,
    REG_DELAY_LIMIT   = 3'd4,
    REG_DOUBLING_MODE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] command;
    logic       congested;
    logic       is_tail;
    logic       new_destination;
  } in_word_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               may_start;
  } out_word_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_value;
    logic [TIMER_W-1:0] decay_timer;
    logic [WAIT_W-1:0]  wait_count;
    logic               tail_done;
  } state_t;

  localparam int STATE_W = $bits(state_t);

  localparam state_t STATE_RESET = '{
    delay_value: '0,
    decay_timer: '0,
    wait_count:  '0,
    tail_done:   1'b1
  };

  localparam logic [WAIT_W-1:0]  WAIT_MAX  = {WAIT_W{1'b1}};
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  localparam logic [15:0] DECAY_PERIOD_RST = 16'd1000;
  localparam logic [7:0]  WAIT_SCALE_RST   = 8'd1;
  localparam logic [15:0] DELAY_STEP_RST   = 16'd1;
  localparam logic [15:0] DELAY_LIMIT_RST  = 16'd64;

endpackage

`default_nettype wire

// File: rtl/ecn_injection_delay_control.sv
// Top level of the congestion-notification injection throttle.
// Depends on ecnidc_pkg and ecnidc_ram (flow state record storage).
//
// Usage:
//   cfg channel: write register cfg_index with cfg_data; cfg_ready is always high.
//     Write only while the block is idle. Indexes past the register list are ignored.
//   item channel: one word per event (tick, ack, flit sent, flow start).
//   result channel: one word per item, in order: the delay after the item and
//     whether a new packet may start.
// A word accepted passes the update and compare stages into the result register.
// Throughput: one word per cycle while result_ready is high. The flow state lives
//   in a one-entry RAM with registered read; the update of word n+1 takes word n's
//   state from a forward register, so reads and write-backs overlap without stalls.
// Pipeline: read / state update and write-back / delay*scale compare into the
//   result register. Each stage holds when the one after it is full and stalled,
//   so up to three words sit in the block while result_ready is low; item_ready
//   drops only when all stages are full.
// Reset: registers take their defaults, the stored state reads as delay 0,
//   timer 0, wait 0, tail done, and the pipeline empties. No clearing pass.
`default_nettype none

module ecn_injection_delay_control (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire ecnidc_pkg::in_word_t  item,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output ecnidc_pkg::out_word_t      result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [ecnidc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ecnidc_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ecnidc_pkg::*;

  localparam int AW = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

  logic [15:0]        decay_period;
  logic               timer_only;
  logic [SCALE_W-1:0] wait_scale;
  logic [15:0]        delay_step;
  logic [15:0]        delay_limit;
  logic               doubling_mode;

  logic     s1_valid;
  in_word_t s1_word;
  logic     s2_valid;
  logic [DELAY_W-1:0] s2_delay;
  logic [WAIT_W-1:0]  s2_wait;
  logic               s2_tail;

  logic   mem_valid;
  logic   fwd_hit;
  state_t fwd_state;
  state_t rd_state;
  logic [STATE_W-1:0] rd_data;

  logic out_en, s2_en, s1_en, accept, commit;
  state_t cur, st_next;
  logic [TIMER_W-1:0] timer_inc;
  logic [DELAY_W:0]   dbl, sum;
  logic [WAIT_W-1:0]  prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_period  <= DECAY_PERIOD_RST;
      timer_only    <= 1'b0;
      wait_scale    <= WAIT_SCALE_RST;
      delay_step    <= DELAY_STEP_RST;
      delay_limit   <= DELAY_LIMIT_RST;
      doubling_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DECAY_PERIOD:  decay_period  <= cfg_data;
        REG_TIMER_ONLY:    timer_only    <= cfg_data[0];
        REG_WAIT_SCALE:    wait_scale    <= cfg_data[SCALE_W-1:0];
        REG_DELAY_STEP:    delay_step    <= cfg_data;
        REG_DELAY_LIMIT:   delay_limit   <= cfg_data;
        REG_DOUBLING_MODE: doubling_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_en     = !result_valid || result_ready;
  assign s2_en      = !s2_valid || out_en;
  assign s1_en      = !s1_valid || s2_en;
  assign item_ready = s1_en;
  assign accept     = item_valid && s1_en;
  assign commit     = s1_valid && s2_en;

  ecnidc_ram #(
    .WIDTH(STATE_W),
    .DEPTH(STATE_DEPTH)
  ) u_state_ram (
    .clk    (clk),
    .wr_en  (commit),
    .wr_addr(AW'(0)),
    .wr_data(st_next),
    .rd_en  (accept),
    .rd_addr(AW'(0)),
    .rd_data(rd_data)
  );

  assign rd_state = state_t'(rd_data);

  always_comb begin
    if (fwd_hit) begin
      cur = fwd_state;
    end else if (mem_valid) begin
      cur = rd_state;
    end else begin
      cur = STATE_RESET;
    end
  end

  assign timer_inc = (cur.decay_timer != TIMER_MAX) ? cur.decay_timer + 1'b1 : cur.decay_timer;
  assign dbl = {cur.delay_value, 1'b0};
  assign sum = {1'b0, cur.delay_value} + {1'b0, delay_step};

  always_comb begin
    st_next = cur;
    case (cmd_t'(s1_word.command))
      CMD_TICK: begin
        if (cur.tail_done && cur.delay_value != '0 && cur.wait_count != WAIT_MAX) begin
          st_next.wait_count = cur.wait_count + 1'b1;
        end
        if (cur.delay_value != '0) begin
          if (timer_inc >= decay_period) begin
            st_next.delay_value = cur.delay_value - 1'b1;
            st_next.decay_timer = '0;
          end else begin
            st_next.decay_timer = timer_inc;
          end
        end
      end
      CMD_ACK: begin
        if (!s1_word.congested) begin
          if (!timer_only) begin
            if (cur.delay_value != '0) begin
              st_next.delay_value = cur.delay_value - 1'b1;
            end
            st_next.decay_timer = '0;
          end
        end else if (doubling_mode) begin
          if (cur.delay_value == '0) begin
            st_next.delay_value = delay_step;
          end else if (dbl > {1'b0, delay_limit}) begin
            st_next.delay_value = delay_limit;
          end else begin
            st_next.delay_value = dbl[DELAY_W-1:0];
          end
        end else if (cur.delay_value < delay_limit) begin
          if (sum > {1'b0, delay_limit}) begin
            st_next.delay_value = delay_limit;
          end else begin
            st_next.delay_value = sum[DELAY_W-1:0];
          end
        end
      end
      CMD_FLIT: begin
        st_next.tail_done = s1_word.is_tail;
        if (s1_word.is_tail) begin
          st_next.wait_count = '0;
        end
      end
      CMD_START: begin
        if (s1_word.new_destination) begin
          st_next.delay_value = '0;
          st_next.decay_timer = '0;
          st_next.wait_count  = '0;
        end
        st_next.tail_done = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      mem_valid    <= 1'b0;
      fwd_hit      <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= item_valid;
        fwd_hit  <= commit;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (out_en) begin
        result_valid <= s2_valid;
      end
      if (commit) begin
        mem_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= item;
    end
    if (commit) begin
      fwd_state <= st_next;
      s2_delay  <= st_next.delay_value;
      s2_wait   <= st_next.wait_count;
      s2_tail   <= st_next.tail_done;
    end
    if (s2_valid && out_en) begin
      result.delay     <= s2_delay;
      result.may_start <= !s2_tail || (s2_wait >= prod);
    end
  end

  assign prod = s2_delay * wait_scale;

  a_commit_fills_s2: assert property (@(posedge clk) disable iff (rst)
    commit |=> s2_valid)
    else $error("committed word did not reach the compare stage");

  a_s2_fills_out: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && out_en) |=> result_valid)
    else $error("compare stage word did not reach the result register");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> mem_valid)
    else $error("forward hit without any state write-back");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_en) |=> (s1_valid && $stable(s1_word)))
    else $error("stalled update stage lost its word");

endmodule

`default_nettype wire

// File: rtl/ecnidc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameterized by word width and depth; no dependencies.
`default_nettype none

module ecnidc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
